>>> hdl/brf_pkg.sv
package brf_pkg;

    // Command codes
    localparam logic [3:0] CMD_READ        = 4'd0;
    localparam logic [3:0] CMD_WRITE       = 4'd1;
    localparam logic [3:0] CMD_WRITE_NOPC  = 4'd2;
    localparam logic [3:0] CMD_READ_USER   = 4'd3;
    localparam logic [3:0] CMD_WRITE_USER  = 4'd4;
    localparam logic [3:0] CMD_MODE        = 4'd5;
    localparam logic [3:0] CMD_STATUS      = 4'd6;
    localparam logic [3:0] CMD_SET_NZ      = 4'd7;
    localparam logic [3:0] CMD_PENDING     = 4'd8;
    localparam logic [3:0] CMD_PROCESS     = 4'd9;

    // Mode codes
    localparam logic [4:0] M_USR = 5'h10;
    localparam logic [4:0] M_FIQ = 5'h11;
    localparam logic [4:0] M_IRQ = 5'h12;
    localparam logic [4:0] M_SVC = 5'h13;
    localparam logic [4:0] M_ABT = 5'h17;
    localparam logic [4:0] M_UND = 5'h1b;
    localparam logic [4:0] M_SYS = 5'h1f;

    // Status word bits
    localparam int BIT_N = 31;
    localparam int BIT_Z = 30;
    localparam int BIT_I = 7;
    localparam int BIT_F = 6;
    localparam int BIT_T = 5;

    // Exception kinds
    localparam logic [2:0] EXC_NONE  = 3'd0;
    localparam logic [2:0] EXC_RESET = 3'd1;
    localparam logic [2:0] EXC_UNDEF = 3'd2;
    localparam logic [2:0] EXC_SWI   = 3'd3;
    localparam logic [2:0] EXC_PABT  = 3'd4;
    localparam logic [2:0] EXC_DABT  = 3'd5;
    localparam logic [2:0] EXC_FIQ   = 3'd6;
    localparam logic [2:0] EXC_IRQ   = 3'd7;

    // Vector offsets
    localparam logic [31:0] VEC_UNDEF = 32'h4;
    localparam logic [31:0] VEC_SWI   = 32'h8;
    localparam logic [31:0] VEC_PABT  = 32'hc;
    localparam logic [31:0] VEC_DABT  = 32'h10;
    localparam logic [31:0] VEC_IRQ   = 32'h18;
    localparam logic [31:0] VEC_FIQ   = 32'h1c;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [3:0]  reg_num;
        logic [31:0] data_in;
        logic [4:0]  target_mode;
        logic [31:0] status_mask;
        logic        set_flag;
        logic [6:0]  event_mask;
        logic [31:0] current_pc;
    } brf_req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [31:0] status_out;
        logic [31:0] saved_status_out;
        logic        exception_taken;
        logic [2:0]  exception_kind;
        logic        pc_resync;
    } brf_rsp_t;

    // Complete architectural state; bank3 holds irq, svc, abort, undef
    typedef struct {
        logic [31:0] vis [16];
        logic [31:0] usr_sp_lr [2];
        logic [31:0] usr_hi [5];
        logic [31:0] fiq_bank [8];
        logic [31:0] bank3 [4][3];
        logic [31:0] status;
        logic [31:0] spsr;
        logic [6:0]  pend;
        logic        dirty;
    } brf_state_t;

    // Index of a three-entry bank for a mode, with a hit flag
    function automatic logic [2:0] bank3_sel(input logic [4:0] m);
        logic [2:0] r;
        begin
            case (m)
                M_IRQ:   r = 3'b100;
                M_SVC:   r = 3'b101;
                M_ABT:   r = 3'b110;
                M_UND:   r = 3'b111;
                default: r = 3'b000;
            endcase
            return r;
        end
    endfunction

    function automatic brf_state_t write_reg(input brf_state_t s, input logic [3:0] n,
                                             input logic [31:0] v);
        brf_state_t r;
        begin
            r = s;
            if (n == 4'd15)
            begin
                r.vis[15] = {v[31:1], 1'b0};
                r.dirty   = 1'b1;
            end
            else
            begin
                r.vis[n] = v;
            end
            return r;
        end
    endfunction

    function automatic brf_state_t switch_mode(input brf_state_t s, input logic [4:0] nm);
        brf_state_t r;
        logic [4:0] old;
        logic [2:0] sel;
        begin
            r   = s;
            old = s.status[4:0];
            if (old != nm)
            begin
                // Save the outgoing bank; leaving FIQ also restores the user r8-r12
                sel = bank3_sel(old);
                if (old == M_USR || old == M_SYS)
                begin
                    r.usr_sp_lr[0] = r.vis[13];
                    r.usr_sp_lr[1] = r.vis[14];
                end
                else if (old == M_FIQ)
                begin
                    for (int i = 0; i < 7; i++)
                        r.fiq_bank[i] = r.vis[8 + i];
                    r.fiq_bank[7] = r.spsr;
                    for (int i = 0; i < 5; i++)
                        r.vis[8 + i] = r.usr_hi[i];
                end
                else if (sel[2])
                begin
                    r.bank3[sel[1:0]][0] = r.vis[13];
                    r.bank3[sel[1:0]][1] = r.vis[14];
                    r.bank3[sel[1:0]][2] = r.spsr;
                end
                // Restore the incoming bank; entering FIQ first saves the user r8-r12
                sel = bank3_sel(nm);
                if (nm == M_USR || nm == M_SYS)
                begin
                    r.vis[13] = r.usr_sp_lr[0];
                    r.vis[14] = r.usr_sp_lr[1];
                end
                else if (nm == M_FIQ)
                begin
                    for (int i = 0; i < 5; i++)
                        r.usr_hi[i] = r.vis[8 + i];
                    for (int i = 0; i < 7; i++)
                        r.vis[8 + i] = r.fiq_bank[i];
                    r.spsr = r.fiq_bank[7];
                end
                else if (sel[2])
                begin
                    r.vis[13] = r.bank3[sel[1:0]][0];
                    r.vis[14] = r.bank3[sel[1:0]][1];
                    r.spsr    = r.bank3[sel[1:0]][2];
                end
                r.status[4:0] = nm;
            end
            return r;
        end
    endfunction

    function automatic brf_state_t enter(input brf_state_t s, input logic [4:0] m,
                                         input logic [31:0] ret, input logic [31:0] vec,
                                         input logic set_f);
        brf_state_t r;
        logic [31:0] old;
        begin
            old = s.status;
            r = write_reg(s, 4'd15, vec);
            r.status[BIT_T] = 1'b0;
            r.status[BIT_I] = 1'b1;
            if (set_f)
                r.status[BIT_F] = 1'b1;
            r = switch_mode(r, m);
            r.vis[14] = ret;
            r.spsr    = old;
            return r;
        end
    endfunction

endpackage

>>> hdl/brf_if.sv
interface brf_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  cmd;
    logic [3:0]  reg_num;
    logic [31:0] data_in;
    logic [4:0]  target_mode;
    logic [31:0] status_mask;
    logic        set_flag;
    logic [6:0]  event_mask;
    logic [31:0] current_pc;

    modport source (output valid, cmd, reg_num, data_in, target_mode, status_mask,
                    set_flag, event_mask, current_pc, input ready);
    modport sink (input valid, cmd, reg_num, data_in, target_mode, status_mask,
                  set_flag, event_mask, current_pc, output ready);
endinterface

interface brf_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic [31:0] status_out;
    logic [31:0] saved_status_out;
    logic        exception_taken;
    logic [2:0]  exception_kind;
    logic        pc_resync;

    modport source (output valid, read_data, status_out, saved_status_out,
                    exception_taken, exception_kind, pc_resync, input ready);
    modport sink (input valid, read_data, status_out, saved_status_out,
                  exception_taken, exception_kind, pc_resync, output ready);
endinterface

interface brf_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

>>> hdl/brf_core.sv
module brf_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  brf_pkg::brf_req_t req,
    input  logic [31:0]       vector_base,
    output brf_pkg::brf_rsp_t rsp
);

    brf_pkg::brf_state_t st_reg;
    brf_pkg::brf_state_t st_next;

    // Execute one command against the current state
    always_comb
    begin
        logic [4:0]  mode;
        logic        usr;
        logic [31:0] rd;
        logic [2:0]  kind;
        logic [31:0] t;
        logic [31:0] ret_near;
        logic [31:0] ret_far;
        st_next  = st_reg;
        mode     = st_reg.status[4:0];
        usr      = (mode == brf_pkg::M_USR) || (mode == brf_pkg::M_SYS);
        rd       = '0;
        kind     = brf_pkg::EXC_NONE;
        t        = {31'd0, st_reg.status[brf_pkg::BIT_T]};
        ret_near = req.current_pc + t;
        ret_far  = req.current_pc + 32'd4 + t;
        case (req.cmd)
            brf_pkg::CMD_READ:
            begin
                rd = st_reg.vis[req.reg_num];
            end
            brf_pkg::CMD_WRITE:
            begin
                st_next = brf_pkg::write_reg(st_reg, req.reg_num, req.data_in);
            end
            brf_pkg::CMD_WRITE_NOPC:
            begin
                if (req.reg_num != 4'd15)
                    st_next.vis[req.reg_num] = req.data_in;
            end
            brf_pkg::CMD_READ_USER:
            begin
                if ((req.reg_num inside {4'd13, 4'd14}) && !usr)
                    rd = st_reg.usr_sp_lr[!req.reg_num[0]];
                else if ((req.reg_num inside {[4'd8:4'd12]}) && mode == brf_pkg::M_FIQ)
                    rd = st_reg.usr_hi[req.reg_num[2:0]];
                else
                    rd = st_reg.vis[req.reg_num];
            end
            brf_pkg::CMD_WRITE_USER:
            begin
                if ((req.reg_num inside {4'd13, 4'd14}) && !usr)
                    st_next.usr_sp_lr[!req.reg_num[0]] = req.data_in;
                else if ((req.reg_num inside {[4'd8:4'd12]}) && mode == brf_pkg::M_FIQ)
                    st_next.usr_hi[req.reg_num[2:0]] = req.data_in;
                else
                    st_next = brf_pkg::write_reg(st_reg, req.reg_num, req.data_in);
            end
            brf_pkg::CMD_MODE:
            begin
                st_next = brf_pkg::switch_mode(st_reg, req.target_mode);
            end
            brf_pkg::CMD_STATUS:
            begin
                if (req.set_flag)
                    st_next.status = st_reg.status | req.status_mask;
                else
                    st_next.status = st_reg.status & ~req.status_mask;
            end
            brf_pkg::CMD_SET_NZ:
            begin
                st_next.status[brf_pkg::BIT_N] = req.data_in[31];
                st_next.status[brf_pkg::BIT_Z] = (req.data_in == '0);
            end
            brf_pkg::CMD_PENDING:
            begin
                if (req.set_flag)
                    st_next.pend = st_reg.pend | req.event_mask;
                else
                    st_next.pend = st_reg.pend & ~req.event_mask;
            end
            brf_pkg::CMD_PROCESS:
            begin
                // Take the highest-priority pending exception that is not masked
                if (st_reg.pend[0])
                begin
                    st_next.status = '0;
                    st_next.status[brf_pkg::BIT_I] = 1'b1;
                    st_next.status[brf_pkg::BIT_F] = 1'b1;
                    st_next = brf_pkg::write_reg(st_next, 4'd15, vector_base);
                    st_next = brf_pkg::switch_mode(st_next, brf_pkg::M_SVC);
                    st_next.pend = st_reg.pend & 7'h60;
                    kind = brf_pkg::EXC_RESET;
                end
                else if (st_reg.pend[1])
                begin
                    st_next = brf_pkg::enter(st_reg, brf_pkg::M_UND, ret_near,
                                             vector_base + brf_pkg::VEC_UNDEF, 1'b0);
                    st_next.pend[1] = 1'b0;
                    kind = brf_pkg::EXC_UNDEF;
                end
                else if (st_reg.pend[2])
                begin
                    st_next = brf_pkg::enter(st_reg, brf_pkg::M_SVC, ret_near,
                                             vector_base + brf_pkg::VEC_SWI, 1'b0);
                    st_next.pend[2] = 1'b0;
                    kind = brf_pkg::EXC_SWI;
                end
                else if (st_reg.pend[3])
                begin
                    st_next = brf_pkg::enter(st_reg, brf_pkg::M_ABT, ret_far,
                                             vector_base + brf_pkg::VEC_PABT, 1'b0);
                    st_next.pend[3] = 1'b0;
                    kind = brf_pkg::EXC_PABT;
                end
                else if (st_reg.pend[4])
                begin
                    st_next = brf_pkg::enter(st_reg, brf_pkg::M_ABT, ret_far,
                                             vector_base + brf_pkg::VEC_DABT, 1'b0);
                    st_next.pend[4] = 1'b0;
                    kind = brf_pkg::EXC_DABT;
                end
                else if (st_reg.pend[5] && !st_reg.status[brf_pkg::BIT_F])
                begin
                    st_next = brf_pkg::enter(st_reg, brf_pkg::M_FIQ, ret_far,
                                             vector_base + brf_pkg::VEC_FIQ, 1'b1);
                    kind = brf_pkg::EXC_FIQ;
                end
                else if (st_reg.pend[6] && !st_reg.status[brf_pkg::BIT_I])
                begin
                    st_next = brf_pkg::enter(st_reg, brf_pkg::M_IRQ, ret_far,
                                             vector_base + brf_pkg::VEC_IRQ, 1'b0);
                    kind = brf_pkg::EXC_IRQ;
                end
            end
            default:
            begin
            end
        endcase
        rsp.read_data        = rd;
        rsp.status_out       = st_next.status;
        rsp.saved_status_out = st_next.spsr;
        rsp.exception_taken  = (kind != brf_pkg::EXC_NONE);
        rsp.exception_kind   = kind;
        rsp.pc_resync        = st_next.dirty;
    end

    // Architectural state register, updated on each accepted transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '{default: '0};
        else if (accept)
            st_reg <= st_next;
    end

endmodule

>>> hdl/banked_register_file_exception_entry.sv
// Banked register file with exception entry.
// The req channel carries one command per transfer; the rsp channel returns
// exactly one result per command, in order. The cfg channel writes the
// vector base and is always ready; write it only while no command is in flight.
// The result is registered and valid in the cycle after the command transfer.
// One command per cycle while results are taken; all state is updated in a single pass
// of logic between the state registers and the result register.
// req.ready is high whenever the result register is empty or being drained,
// so a stalled receiver holds the result and back-pressures new commands,
// with no command lost.
// Reset clears every register, the banks, the status words, the pending
// bits, the PC resync flag and the vector base; the block is ready at once.
module banked_register_file_exception_entry (
    input logic       clk,
    input logic       rst_n,
    brf_cfg_if.sink   cfg,
    brf_req_if.sink   req,
    brf_rsp_if.source rsp
);

    logic [31:0]       vector_base_reg;
    logic              out_valid_reg;
    brf_pkg::brf_rsp_t out_reg;
    brf_pkg::brf_rsp_t core_rsp;
    brf_pkg::brf_req_t cmd_word;
    logic              accept;

    assign cfg.ready = 1'b1;
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign cmd_word = '{cmd: req.cmd, reg_num: req.reg_num, data_in: req.data_in,
                        target_mode: req.target_mode, status_mask: req.status_mask,
                        set_flag: req.set_flag, event_mask: req.event_mask,
                        current_pc: req.current_pc};

    brf_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .req         (cmd_word),
        .vector_base (vector_base_reg),
        .rsp         (core_rsp)
    );

    // Vector base register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vector_base_reg <= '0;
        else if (cfg.valid)
            vector_base_reg <= cfg.data;
    end

    // Result register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= core_rsp;
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.read_data        = out_reg.read_data;
    assign rsp.status_out       = out_reg.status_out;
    assign rsp.saved_status_out = out_reg.saved_status_out;
    assign rsp.exception_taken  = out_reg.exception_taken;
    assign rsp.exception_kind   = out_reg.exception_kind;
    assign rsp.pc_resync        = out_reg.pc_resync;

    // A held result blocks new commands
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |-> !req.ready)
        else $error("command accepted while a result is stalled");

    // Every accepted command yields a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("result missing after command transfer");

    // Taken flag agrees with the exception kind
    a_kind_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.exception_taken == (out_reg.exception_kind != '0)))
        else $error("exception flag and kind disagree");

    // PC resync never clears once reported
    a_resync_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && out_valid_reg && out_reg.pc_resync) |=> out_reg.pc_resync)
        else $error("pc resync flag cleared");

endmodule
